### rtl/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int OP_W    = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PACKET = 2'd2;

    localparam logic [OP_W-1:0] OPC_REQUEST = 16'd1;
    localparam logic [OP_W-1:0] OPC_REPLY   = 16'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_REPLY   = 3'd1,
        ST_ADDED   = 3'd2,
        ST_HIT     = 3'd3,
        ST_MISS    = 3'd4
    } t_status;

    typedef struct packed {
        logic             wr_en;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_tbl_wr;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
    } t_tbl_rsp;

endpackage

`default_nettype wire

### rtl/arpc_table.sv
`default_nettype none

module arpc_table
    import arpc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [IP_W-1:0] i_lookup_ip,
    input  wire t_tbl_wr         i_wr,
    output t_tbl_rsp             o_rsp
);

    logic [IP_W-1:0]  r_ip    [ENTRIES];
    logic [MAC_W-1:0] r_mac   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [IDX_W-1:0] w_slot;

    // Lowest matching valid entry wins, so scan from the top down.
    always_comb begin
        o_rsp.hit = 1'b0;
        o_rsp.mac = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_ip[i] == i_lookup_ip)) begin
                o_rsp.hit = 1'b1;
                o_rsp.mac = r_mac[i];
            end
        end
    end

    // Lowest free entry; entry 0 is reused when the table is full.
    always_comb begin
        w_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_slot = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.wr_en) begin
            r_valid[w_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_ip[w_slot]  <= i_wr.ip;
            r_mac[w_slot] <= i_wr.mac;
        end
    end

    // Entries are never invalidated outside reset.
    a_valid_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_valid) >= $past($countones(r_valid)))
        else $error("valid entry count dropped");

    // At most one entry becomes valid per write; a write into a full table lands in entry 0 and keeps the count.
    a_one_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_valid) <= $past($countones(r_valid)) + 1)
        else $error("more than one entry became valid");

endmodule

`default_nettype wire

### rtl/arp_cache_and_responder_top.sv
// Data path: an accepted beat passes through the input register, then the result
// register, which holds its result while i_ready is low.
// Throughput: one beat per cycle while i_ready is high, set by the parallel
// combinational match and free-entry pick over all table entries between the two registers.
// Reset (synchronous, active low) invalidates every table entry, clears own_ip
// and empties both pipeline registers.
`default_nettype none

module arp_cache_and_responder_top
    import arpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,

    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [IP_W-1:0]      i_ip_key,
    input  wire logic [MAC_W-1:0]     i_hw_addr,
    input  wire logic [OP_W-1:0]      i_arp_op,
    input  wire logic [IP_W-1:0]      i_target_addr,

    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_status,
    output logic [MAC_W-1:0]          o_mac_out,
    output logic [IP_W-1:0]           o_reply_ip
);

    logic [IP_W-1:0]  r_own_ip;

    logic             r_in_vld;
    logic [MODE_W-1:0] r_mode;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;
    logic [OP_W-1:0]  r_op;
    logic [IP_W-1:0]  r_target;

    logic             r_out_vld;
    t_status          r_status;
    logic [MAC_W-1:0] r_mac_out;
    logic [IP_W-1:0]  r_reply_ip;

    t_status          n_status;
    logic [MAC_W-1:0] n_mac_out;
    logic [IP_W-1:0]  n_reply_ip;

    logic             w_adv;
    logic             w_learn;
    t_tbl_wr          w_wr;
    t_tbl_rsp         w_rsp;

    // The own MAC register is not kept here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == REG_OWN_IP)) begin
            r_own_ip <= i_cfg_data[IP_W-1:0];
        end
    end

    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode   <= i_mode;
            r_ip     <= i_ip_key;
            r_mac    <= i_hw_addr;
            r_op     <= i_arp_op;
            r_target <= i_target_addr;
        end
    end

    arpc_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup_ip (r_ip),
        .i_wr        (w_wr),
        .o_rsp       (w_rsp)
    );

    always_comb begin
        n_status   = ST_IGNORED;
        n_mac_out  = '0;
        n_reply_ip = '0;
        w_learn    = 1'b0;
        unique case (r_mode)
            MODE_LOOKUP: begin
                if (w_rsp.hit) begin
                    n_status  = ST_HIT;
                    n_mac_out = w_rsp.mac;
                end else begin
                    n_status = ST_MISS;
                end
            end
            MODE_ADD: begin
                n_status = ST_ADDED;
                w_learn  = 1'b1;
            end
            MODE_PACKET: begin
                if ((r_op == OPC_REQUEST) && (r_target == r_own_ip)) begin
                    n_status   = ST_REPLY;
                    n_mac_out  = r_mac;
                    n_reply_ip = r_ip;
                end else if (r_op == OPC_REPLY) begin
                    n_status = ST_ADDED;
                    w_learn  = 1'b1;
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    // The table write lands on the same edge the result is registered, so the
    // next beat already sees it.
    assign w_wr.wr_en = r_in_vld && w_adv && w_learn;
    assign w_wr.ip    = r_ip;
    assign w_wr.mac   = r_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_vld) begin
            r_status   <= n_status;
            r_mac_out  <= n_mac_out;
            r_reply_ip <= n_reply_ip;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_status;
    assign o_mac_out  = r_mac_out;
    assign o_reply_ip = r_reply_ip;

    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status != ST_HIT) && (r_status != ST_REPLY))
            |-> (r_mac_out == '0))
        else $error("MAC out nonzero without hit or reply");

    a_reply_ip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status != ST_REPLY)) |-> (r_reply_ip == '0))
        else $error("reply IP nonzero without reply");

    a_learn_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.wr_en |=> (r_out_vld && (r_status == ST_ADDED)))
        else $error("table write without an added result");

endmodule

`default_nettype wire
